FILE: rtl/core/pdrt_pkg.sv
// ----------------------------------------------------------------------------
// pdrt_pkg
// Shared types, register indexes and operation codes of the prescaled divider
// and reload timer.
// ----------------------------------------------------------------------------
package pdrt_pkg;

    // Widths of the item fields and of the internal counters.
    localparam int unsigned CountW     = 8;
    localparam int unsigned CyclesW    = 8;
    localparam int unsigned PreAccumW  = 10;
    localparam int unsigned SelW       = 2;
    localparam int unsigned CfgIndexW  = 2;
    localparam int unsigned CfgDataW   = 8;
    localparam int unsigned ShiftW     = 4;

    // Operation codes of an input word.
    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } t_func;

    // Configuration register indexes.
    localparam logic [CfgIndexW-1:0] CFG_TIMER_ENABLE = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_CLOCK_SELECT = 2'd1;
    localparam logic [CfgIndexW-1:0] CFG_RELOAD_VALUE = 2'd2;

    // Prescale period selections.
    localparam logic [SelW-1:0] SEL_1024 = 2'd0;
    localparam logic [SelW-1:0] SEL_16   = 2'd1;
    localparam logic [SelW-1:0] SEL_64   = 2'd2;
    localparam logic [SelW-1:0] SEL_256  = 2'd3;

    // Architectural state of the timer.
    typedef struct packed {
        logic [CountW-1:0]    div_accum;
        logic [CountW-1:0]    div_count;
        logic [PreAccumW-1:0] pre_accum;
        logic [CountW-1:0]    timer_count;
    } t_state;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic              timer_enable;
        logic [SelW-1:0]   clock_select;
        logic [CountW-1:0] reload_value;
    } t_cfg;

    // Log2 of the prescale period for a clock selection.
    function automatic logic [ShiftW-1:0] period_shift(input logic [SelW-1:0] sel);
        logic [ShiftW-1:0] sh;
        unique case (sel)
            SEL_1024: sh = 4'd10;
            SEL_16:   sh = 4'd4;
            SEL_64:   sh = 4'd6;
            SEL_256:  sh = 4'd8;
            default:  sh = 4'd10;
        endcase
        return sh;
    endfunction

endpackage

FILE: rtl/core/prescaled_divider_and_reload_timer_core.sv
// ----------------------------------------------------------------------------
// prescaled_divider_and_reload_timer_core
// A word accepted into the input register moves on to the result register
// when the result register is free or drained.
// One word per cycle unless the result channel stalls; the input and result
// registers let a new word enter while the previous result still waits.
// Reset (synchronous, active low) clears the divider, accumulators, counter,
// configuration registers and both valid flags.
// ----------------------------------------------------------------------------
module prescaled_divider_and_reload_timer_core
    import pdrt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CfgIndexW-1:0] i_cfg_index,
    input  logic [CfgDataW-1:0]  i_cfg_data,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_func,
    input  logic [CyclesW-1:0]   i_cycles,
    input  logic [CountW-1:0]    i_write_data,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CountW-1:0]    o_divider_value,
    output logic [CountW-1:0]    o_counter_value,
    output logic                 o_overflow_irq
);

    t_cfg                r_cfg;
    t_state              r_state;
    t_state              n_state;
    logic                n_irq;

    logic                r_in_valid;
    t_func               r_in_func;
    logic [CyclesW-1:0]  r_in_cycles;
    logic [CountW-1:0]   r_in_wdata;

    logic                r_out_valid;
    logic [CountW-1:0]   r_out_div;
    logic [CountW-1:0]   r_out_count;
    logic                r_out_irq;

    logic                move;
    logic                in_accept;

    // A word moves to the result register when that register is free or drained.
    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;
    assign in_accept  = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TIMER_ENABLE: r_cfg.timer_enable <= i_cfg_data[0];
                CFG_CLOCK_SELECT: r_cfg.clock_select <= i_cfg_data[SelW-1:0];
                CFG_RELOAD_VALUE: r_cfg.reload_value <= i_cfg_data[CountW-1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_func   <= t_func'(i_func);
            r_in_cycles <= i_cycles;
            r_in_wdata  <= i_write_data;
        end
    end

    // Next-state logic.
    pdrt_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_func       (r_in_func),
        .i_cycles     (r_in_cycles),
        .i_write_data (r_in_wdata),
        .o_state      (n_state),
        .o_irq        (n_irq)
    );

    // Timer state advances as each word moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_div   <= n_state.div_count;
            r_out_count <= n_state.timer_count;
            r_out_irq   <= n_irq;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_divider_value = r_out_div;
    assign o_counter_value = r_out_count;
    assign o_overflow_irq  = r_out_irq;

`ifndef SYNTHESIS
    // A held input word is never dropped.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !move |=> r_in_valid)
        else $error("input word lost while stalled");

    // The divider only changes when a word is processed.
    a_div_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !move |=> $stable(r_state.div_count))
        else $error("divider changed without a word");

    // A tick with the timer disabled leaves the prescale accumulator empty.
    a_pre_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_in_func == FUNC_TICK && !r_cfg.timer_enable |=> r_state.pre_accum == '0)
        else $error("prescale accumulator not cleared");

    // A counter write never raises the interrupt.
    a_write_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_in_func == FUNC_WRITE |=> !r_out_irq)
        else $error("interrupt raised by a counter write");
`endif

endmodule

FILE: rtl/core/pdrt_step.sv
// ----------------------------------------------------------------------------
// pdrt_step
// Next-state logic of the timer for one word: divider, prescale accumulator
// and counter with reload.
// ----------------------------------------------------------------------------
module pdrt_step
    import pdrt_pkg::*;
(
    input  t_state                 i_state,
    input  t_cfg                   i_cfg,
    input  t_func                  i_func,
    input  logic [CyclesW-1:0]     i_cycles,
    input  logic [CountW-1:0]      i_write_data,
    output t_state                 o_state,
    output logic                   o_irq
);

    logic [CountW:0]      dsum;
    logic [PreAccumW:0]   psum;
    logic [ShiftW-1:0]    sh;
    logic [PreAccumW:0]   mask;
    logic [PreAccumW:0]   periods;
    logic [PreAccumW+1:0] next_count;

    // Divider: one increment whenever the accumulator sum reaches 256 and wraps.
    assign dsum = {1'b0, i_state.div_accum} + {1'b0, i_cycles};

    // Prescaler: whole periods go to the counter, the remainder stays.
    assign sh         = period_shift(i_cfg.clock_select);
    assign psum       = {1'b0, i_state.pre_accum} + (PreAccumW+1)'(i_cycles);
    assign mask       = ((PreAccumW+1)'(1) << sh) - (PreAccumW+1)'(1);
    assign periods    = psum >> sh;
    assign next_count = (PreAccumW+2)'(i_state.timer_count) + {1'b0, periods};

    // Select the new state according to the operation.
    always_comb begin
        o_state = i_state;
        o_irq   = 1'b0;
        unique case (i_func)
            FUNC_WRITE: begin
                o_state.timer_count = i_write_data;
            end
            FUNC_TICK: begin
                o_state.div_accum = dsum[CountW-1:0];
                if (dsum[CountW]) begin
                    o_state.div_count = i_state.div_count + CountW'(1);
                end
                if (i_cfg.timer_enable) begin
                    o_state.pre_accum = PreAccumW'(psum & mask);
                    if (next_count > (PreAccumW+2)'(255)) begin
                        o_state.timer_count = i_cfg.reload_value;
                        o_irq               = 1'b1;
                    end else begin
                        o_state.timer_count = next_count[CountW-1:0];
                    end
                end else begin
                    o_state.pre_accum = '0;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule
